// ===== hdl/bkvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkvm_pkg
// Shared types and constants for the bucketed key/value map.
// ----------------------------------------------------------------------------
package bkvm_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int BC_W    = 7;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam int MAX_BUCKETS_DEF      = 64;
	localparam int SLOTS_PER_BUCKET_DEF = 4;

	localparam logic [BC_W-1:0] BC_RESET = 7'd64;

	// register index is paddr[2]
	localparam logic REG_BUCKET_COUNT = 1'b0;

	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic                    ok;
		logic signed [VAL_W-1:0] value_out;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_ACT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic scan_issue;
		logic commit;
		logic clr_start;
		logic clr_step;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;
		logic scan_done;
		logic clr_last;
		logic out_busy;
	} st_t;

endpackage
`default_nettype wire

// ===== hdl/bucketed_key_value_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_key_value_map
// Key/value map, bucket = key mod clamped bucket_count, fixed slots per bucket.
//
//   channel  signals                          transfer when
//   req      req_valid/req_ready/req_data     req_valid & req_ready
//   rsp      rsp_valid/rsp_ready/rsp_data     rsp_valid & rsp_ready
//   apb      psel/penable/pwrite/paddr/...    psel & penable & pwrite
//
// Each item is loaded, passes the bit-serial remainder unit, then the bucket
// scan on the single slot memory read port, one read per slot, and commits.
// Reset and every bucket_count write start a clearing pass over all
// MAX_BUCKETS * SLOTS_PER_BUCKET slots with req_ready low. A stalled
// result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module bucketed_key_value_map
	import bkvm_pkg::*;
#(
	parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp_data
);

	logic [BC_W-1:0] bc_q;
	logic            cfg_clr;
	ctl_t            ctl;
	st_t             st;

	assign pready  = 1'b1;
	assign cfg_clr = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= BC_RESET;
		end else if (cfg_clr) begin
			bc_q <= pwdata[BC_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? APB_DW'(bc_q) : '0;

	bkvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_clr   (cfg_clr),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.ctl       (ctl)
	);

	bkvm_dp #(
		.MAX_BUCKETS      (MAX_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.bucket_count (bc_q),
		.req_data     (req_data),
		.ctl          (ctl),
		.st           (st),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp_data     (rsp_data)
	);

endmodule
`default_nettype wire

// ===== hdl/bkvm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkvm_ctrl
// Sequencer: table clear, remainder, bucket scan, commit.
// ----------------------------------------------------------------------------
module bkvm_ctrl
	import bkvm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_clr,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire st_t  st,
	output ctl_t      ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		if (cfg_clr) begin
			ctl.clr_start = 1'b1;
			state_d       = ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					ctl.clr_step = 1'b1;
					if (st.clr_last) begin
						state_d = ST_IDLE;
					end
				end
				ST_IDLE: begin
					req_ready = 1'b1;
					if (req_valid) begin
						ctl.load = 1'b1;
						state_d  = ST_DIV;
					end
				end
				ST_DIV: begin
					ctl.div_step = 1'b1;
					if (st.div_last) begin
						state_d = ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (st.scan_done) begin
						state_d = ST_ACT;
					end else begin
						ctl.scan_issue = 1'b1;
					end
				end
				ST_ACT: begin
					if (!st.out_busy) begin
						ctl.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end
				default: begin
					state_d = ST_CLEAR;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bkvm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkvm_dp
// Datapath: bit-serial key remainder, slot memory, scan and result register.
// ----------------------------------------------------------------------------
module bkvm_dp
	import bkvm_pkg::*;
#(
	parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [BC_W-1:0] bucket_count,
	input  wire req_t            req_data,
	input  wire ctl_t            ctl,
	output st_t                  st,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output rsp_t                 rsp_data
);

	localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int DCW   = $clog2(KEY_W);
	localparam int EW    = 1 + KEY_W + VAL_W;

	// entry: {valid, key, value}
	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	logic [1:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [KEY_W-1:0] quo_q;
	logic [BC_W-1:0]  rem_q;
	logic [BC_W-1:0]  div_q;
	logic [DCW-1:0]   dcnt_q;
	logic [BC_W-1:0]  eff;
	logic [BC_W:0]    trial;

	logic [CW-1:0]    cnt_q;
	logic             all_issued;
	logic [31:0]      base_w;
	logic [AW-1:0]    scan_addr;
	logic             chk_s1;
	logic [AW-1:0]    chk_idx_s1;
	logic             hit_q;
	logic [AW-1:0]    hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             free_q;
	logic [AW-1:0]    free_idx_q;

	logic [AW-1:0]    clr_cnt_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [EW-1:0]    wdata;
	logic             res_ok;
	logic [VAL_W-1:0] res_val;
	logic             out_valid_q;
	rsp_t             out_q;

	always_comb begin
		if (bucket_count == '0) begin
			eff = BC_W'(1);
		end else if (32'(bucket_count) > MAX_BUCKETS) begin
			eff = BC_W'(MAX_BUCKETS);
		end else begin
			eff = bucket_count;
		end
	end

	assign trial = {rem_q, quo_q[KEY_W-1]};

	// restoring remainder, one key bit per cycle, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (ctl.load) begin
			dcnt_q <= '0;
		end else if (ctl.div_step) begin
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req_data.cmd;
			key_q <= req_data.key;
			val_q <= req_data.value_in;
			quo_q <= req_data.key;
			rem_q <= '0;
			div_q <= eff;
		end else if (ctl.div_step) begin
			quo_q <= quo_q << 1;
			if (trial >= {1'b0, div_q}) begin
				rem_q <= BC_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[BC_W-1:0];
			end
		end
	end

	assign st.div_last = (dcnt_q == DCW'(KEY_W - 1));

	// bucket scan: one read issued per cycle, checked from the registered read data rd_q
	assign base_w     = 32'(rem_q) * 32'(SLOTS_PER_BUCKET);
	assign scan_addr  = AW'(base_w + 32'(cnt_q));
	assign all_issued = (cnt_q == CW'(SLOTS_PER_BUCKET));
	// last slot is checked at the edge that leaves the scan
	assign st.scan_done = all_issued;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			chk_s1 <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			chk_s1 <= ctl.scan_issue;
			if (ctl.load) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (ctl.scan_issue) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (chk_s1) begin
					if (rd_q[EW-1] && rd_q[EW-2 -: KEY_W] == key_q && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!rd_q[EW-1] && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= scan_addr;
		if (chk_s1) begin
			if (rd_q[EW-1] && rd_q[EW-2 -: KEY_W] == key_q && !hit_q) begin
				hit_idx_q <= chk_idx_s1;
				hit_val_q <= rd_q[VAL_W-1:0];
			end
			if (!rd_q[EW-1] && !free_q) begin
				free_idx_q <= chk_idx_s1;
			end
		end
	end

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr_start) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr_step) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign st.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

	// commit and clearing-pass writes
	always_comb begin
		we      = 1'b0;
		waddr   = hit_q ? hit_idx_q : free_idx_q;
		wdata   = {1'b1, key_q, val_q};
		res_ok  = 1'b0;
		res_val = '0;
		if (ctl.clr_step) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else if (ctl.commit) begin
			case (cmd_q)
				CMD_PUT: begin
					we     = hit_q || free_q;
					res_ok = hit_q || free_q;
				end
				CMD_GET: begin
					res_ok  = hit_q;
					res_val = hit_q ? hit_val_q : '0;
				end
				CMD_REMOVE: begin
					we     = hit_q;
					wdata  = {1'b0, key_q, val_q};
					res_ok = hit_q;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[scan_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_q.ok        <= res_ok;
			out_q.value_out <= res_val;
		end
	end

	assign st.out_busy = out_valid_q && !rsp_ready;
	assign rsp_valid   = out_valid_q;
	assign rsp_data    = out_q;

`ifndef SYNTH
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!out_valid_q || rsp_ready))
		else $error("commit while result register is held");
	a_no_overscan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_issue |-> !all_issued)
		else $error("scan read issued past bucket end");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (rem_q < div_q))
		else $error("bucket index not below bucket count");
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.commit && ctl.clr_step))
		else $error("commit during clearing pass");
`endif

endmodule
`default_nettype wire
